// File: hw/rtl/lqr_pkg.sv
// Package with the shared types, register indexes and constants of the LQR position loop.
`timescale 1ns / 1ps
package lqr_pkg;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_CORDIC = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_ACC    = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_GAIN_A   = 3'd0,
		CFG_GAIN_B   = 3'd1,
		CFG_GAIN_C   = 3'd2,
		CFG_SETPOINT = 3'd3,
		CFG_INT_LIM  = 3'd4,
		CFG_OUT_LIM  = 3'd5,
		CFG_INTERVAL = 3'd6
	} cfg_idx_t;

	localparam logic [22:0] INT_LIM_RESET  = 23'd32768;
	localparam logic [14:0] OUT_LIM_RESET  = 15'd715;
	localparam logic [15:0] INTERVAL_RESET = 16'd1311;

	// Sine/cosine unit.
	localparam int          CS_W          = 18;
	localparam int          Z_W           = 17;
	localparam logic [3:0]  CORDIC_LAST   = 4'd13;
	localparam logic [17:0] CORDIC_START  = 18'd9949;

	// Micro-operation sequence of the shared multiplier.
	localparam logic [4:0] OP_ROT_LAST    = 5'd7;
	localparam logic [4:0] OP_INT_X       = 5'd8;
	localparam logic [4:0] OP_INT_Y       = 5'd9;
	localparam logic [4:0] OP_ROLL_FIRST  = 5'd10;
	localparam logic [4:0] OP_ROLL_LAST   = 5'd15;
	localparam logic [4:0] OP_PITCH_FIRST = 5'd16;
	localparam logic [4:0] OP_LAST        = 5'd21;

	// Arctangent of 2^-i in units of 1/65536 turn.
	function automatic logic [13:0] atan_entry(input logic [3:0] i);
		logic [13:0] v;
		unique case (i)
			4'd0:    v = 14'd8192;
			4'd1:    v = 14'd4836;
			4'd2:    v = 14'd2555;
			4'd3:    v = 14'd1297;
			4'd4:    v = 14'd651;
			4'd5:    v = 14'd326;
			4'd6:    v = 14'd163;
			4'd7:    v = 14'd81;
			4'd8:    v = 14'd41;
			4'd9:    v = 14'd20;
			4'd10:   v = 14'd10;
			4'd11:   v = 14'd5;
			4'd12:   v = 14'd3;
			4'd13:   v = 14'd1;
			default: v = 14'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/lqr_cordic.sv
// Iterative rotation-mode CORDIC giving the cosine and sine of a binary angle.
`timescale 1ns / 1ps
module lqr_cordic
	import lqr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [15:0]            angle,
	output logic                   done,
	output logic signed [CS_W-1:0] cos_val,
	output logic signed [CS_W-1:0] sin_val
);

	logic                   busy_q, done_q, flip_q;
	logic [3:0]             step_q;
	logic signed [CS_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]  z_q, at;
	logic signed [15:0]     a_s, a_f;
	logic                   wide;

	// Angles beyond a quarter turn are moved by half a turn and the result negated.
	assign a_s  = $signed(angle);
	assign wide = (a_s > 16'sd16384) || (a_s < -16'sd16384);
	assign a_f  = wide ? $signed(angle ^ 16'h8000) : a_s;

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = $signed(Z_W'(atan_entry(step_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == CORDIC_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= $signed(CORDIC_START);
			y_q    <= '0;
			z_q    <= Z_W'(a_f);
			flip_q <= wide;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign done    = done_q;
	assign cos_val = flip_q ? -x_q : x_q;
	assign sin_val = flip_q ? -y_q : y_q;

endmodule

// File: hw/rtl/lqr_position_loop.sv
// Top level of the LQR position loop with integral action.
`timescale 1ns / 1ps
// How to use this block:
// An input word (pos_x, pos_y, vel_x, vel_y, yaw_angle) is taken on the in_valid/in_ready
// channel. The block then works on it alone and holds in_ready low until it is finished.
// The yaw angle first goes through an iterative CORDIC, 14 steps, one per cycle. Then a
// single shared signed multiplier and accumulator runs 22 multiply-accumulate operations,
// each a multiply state and then an accumulate state: eight for the frame rotation, two
// for the integrators and twelve for the gain product. The result word then appears on
// out_valid, and the next word can be taken in the same cycle as it appears. The CORDIC
// loop and the single multiplier set the time that one word takes.
// The result word (roll_command, pitch_command) is held in an output register on the
// out_valid/out_ready channel. If the receiver stalls, the next item is still accepted and
// worked on, and it waits at its end until the output register is free.
// Configuration is written on the cfg_valid/cfg_ready channel, which is always ready.
// Writes should only be made while no item is in progress. Indexes beyond the list are ignored.
// Reset clears the integrators, the gains and the setpoints, and loads the default limits
// and loop interval. No clearing pass is needed.
module lqr_position_loop
	import lqr_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [63:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] pos_x,
	input  logic signed [DATA_WIDTH-1:0] pos_y,
	input  logic signed [DATA_WIDTH-1:0] vel_x,
	input  logic signed [DATA_WIDTH-1:0] vel_y,
	input  logic [15:0]                  yaw_angle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [15:0]           roll_command,
	output logic signed [15:0]           pitch_command
);

	// Error, rotated error, multiplier operand, product, accumulator and integrator sum widths.
	localparam int EW    = ((DATA_WIDTH > 16) ? DATA_WIDTH : 16) + 1;
	localparam int RW    = EW + 1;
	localparam int AW    = (RW > 24) ? RW : 24;
	localparam int PW    = AW + CS_W;
	localparam int ACC_W = PW + 11;
	localparam int IW    = PW + 1;

	logic [63:0] gain_a_q, gain_b_q, gain_c_q, setpoint_q;
	logic [22:0] int_lim_q;
	logic [14:0] out_lim_q;
	logic [15:0] interval_q;

	state_t state_q;
	logic [4:0] op_q;
	logic out_valid_q;
	logic signed [15:0] roll_out_q, pitch_out_q, roll_q, pitch_q;
	logic signed [23:0] int_x_q, int_y_q;

	logic signed [EW-1:0]    e_q [4];
	logic signed [RW-1:0]    r_q [4];
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;

	logic cor_start, cor_done;
	logic signed [CS_W-1:0] cos_v, sin_v;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign cor_start = in_valid && in_ready;

	lqr_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (yaw_angle),
		.done    (cor_done),
		.cos_val (cos_v),
		.sin_val (sin_v)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_a_q   <= '0;
			gain_b_q   <= '0;
			gain_c_q   <= '0;
			setpoint_q <= '0;
			int_lim_q  <= INT_LIM_RESET;
			out_lim_q  <= OUT_LIM_RESET;
			interval_q <= INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GAIN_A:   gain_a_q   <= cfg_data;
				CFG_GAIN_B:   gain_b_q   <= cfg_data;
				CFG_GAIN_C:   gain_c_q   <= cfg_data;
				CFG_SETPOINT: setpoint_q <= cfg_data;
				CFG_INT_LIM:  int_lim_q  <= cfg_data[22:0];
				CFG_OUT_LIM:  out_lim_q  <= cfg_data[14:0];
				CFG_INTERVAL: interval_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The twelve gains in row order: row zero, then row one, six each.
	logic signed [15:0] k_lane [12];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			k_lane[i]     = $signed(gain_a_q[16*i +: 16]);
			k_lane[i + 4] = $signed(gain_b_q[16*i +: 16]);
			k_lane[i + 8] = $signed(gain_c_q[16*i +: 16]);
		end
	end

	// Operand selection for the shared multiplier.
	logic [4:0] g_full;
	logic [3:0] g_idx;
	logic [2:0] j_idx;
	logic signed [AW-1:0]   opa;
	logic signed [CS_W-1:0] opb;
	logic signed [AW-1:0]   r_vec [6];
	logic sub, shl8, clr;

	assign g_full = op_q - OP_ROLL_FIRST;
	assign g_idx  = g_full[3:0];
	assign j_idx  = (g_idx >= 4'd6) ? 3'(g_idx - 4'd6) : g_idx[2:0];

	always_comb begin
		for (int i = 0; i < 4; i++) r_vec[i] = AW'(r_q[i]);
		r_vec[4] = AW'(int_x_q);
		r_vec[5] = AW'(int_y_q);
	end

	always_comb begin
		opa  = '0;
		opb  = '0;
		sub  = 1'b0;
		shl8 = 1'b0;
		clr  = 1'b0;
		if (op_q <= OP_ROT_LAST) begin
			// Pairs: ex = e0*c + e1*s, ey = e1*c - e0*s, and the same for velocities.
			opa = AW'(e_q[{op_q[2], op_q[1] ^ op_q[0]}]);
			opb = op_q[0] ? sin_v : cos_v;
			sub = op_q[1] & op_q[0];
			clr = !op_q[0];
		end else if (op_q == OP_INT_X || op_q == OP_INT_Y) begin
			opa = (op_q == OP_INT_Y) ? AW'(r_q[1]) : AW'(r_q[0]);
			opb = $signed(CS_W'(interval_q));
		end else begin
			opa  = r_vec[j_idx];
			opb  = CS_W'(k_lane[g_idx]);
			shl8 = (j_idx < 3'd4);
			clr  = (op_q == OP_ROLL_FIRST) || (op_q == OP_PITCH_FIRST);
		end
	end

	// Accumulate, round and clamp.
	logic signed [ACC_W-1:0] term, acc_next, acc_rnd14, acc_rnd12, olim;
	logic signed [IW-1:0]    inc, isum, ilim, int_sel;
	logic signed [15:0]      cmd;

	assign term      = shl8 ? (ACC_W'(prod_q) <<< 8) : ACC_W'(prod_q);
	assign acc_next  = (clr ? '0 : acc_q) + (sub ? -term : term);
	assign acc_rnd14 = (acc_next + ACC_W'(1 << 13)) >>> 14;
	assign acc_rnd12 = (acc_next + ACC_W'(1 << 11)) >>> 12;
	assign olim      = $signed(ACC_W'(out_lim_q));

	always_comb begin
		if (acc_rnd12 > olim) cmd = 16'(olim);
		else if (acc_rnd12 < -olim) cmd = 16'(-olim);
		else cmd = 16'(acc_rnd12);
	end

	assign inc     = (IW'(prod_q) + IW'(1 << 7)) >>> 8;
	assign int_sel = (op_q == OP_INT_Y) ? IW'(int_y_q) : IW'(int_x_q);
	assign isum    = int_sel + inc;
	assign ilim    = $signed(IW'(int_lim_q));

	logic signed [23:0] int_new;
	always_comb begin
		if (isum > ilim) int_new = 24'(ilim);
		else if (isum < -ilim) int_new = 24'(-ilim);
		else int_new = 24'(isum);
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			out_valid_q <= 1'b0;
			int_x_q     <= '0;
			int_y_q     <= '0;
		end else begin
			// A finished word enters the output register once it is free or being taken.
			if (state_q == ST_DONE && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CORDIC;
				end
				ST_CORDIC: begin
					op_q <= '0;
					if (cor_done) state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (op_q == OP_INT_X) int_x_q <= int_new;
					if (op_q == OP_INT_Y) int_y_q <= int_new;
					if (op_q == OP_LAST) begin
						state_q <= ST_DONE;
					end else begin
						op_q    <= op_q + 5'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cor_start) begin
			e_q[0] <= EW'($signed(setpoint_q[15:0]))  - EW'(pos_x);
			e_q[1] <= EW'($signed(setpoint_q[31:16])) - EW'(pos_y);
			e_q[2] <= EW'($signed(setpoint_q[47:32])) - EW'(vel_x);
			e_q[3] <= EW'($signed(setpoint_q[63:48])) - EW'(vel_y);
		end
		if (state_q == ST_MUL) prod_q <= opa * opb;
		if (state_q == ST_ACC) begin
			acc_q <= acc_next;
			if (op_q <= OP_ROT_LAST && op_q[0]) r_q[op_q[2:1]] <= RW'(acc_rnd14);
			if (op_q == OP_ROLL_LAST) roll_q <= cmd;
			if (op_q == OP_LAST) pitch_q <= cmd;
		end
		// Both commands move into the output register only when the word is handed over.
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			roll_out_q  <= roll_q;
			pitch_out_q <= pitch_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign roll_command  = roll_out_q;
	assign pitch_command = pitch_out_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("sequencer state is not one-hot");
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> state_q == ST_CORDIC)
		else $error("sine/cosine result arrived outside its wait state");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == ST_CORDIC)
		else $error("accepted word did not start the sine/cosine unit");
	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_ACC) |-> op_q <= OP_LAST)
		else $error("operation counter ran past the last operation");
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished word was not loaded into a free output register");

endmodule
